FILE: hw/rtl/xmt_pkg.sv
`timescale 1ns / 1ps
package xmt_pkg;

  localparam int ENTITY_MAX_DEF = 8;
  localparam int RES_MAX = 3;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_NAME   = 3'd1,
    MODE_STRING = 3'd2,
    MODE_AFTLT  = 3'd3,
    MODE_ENTITY = 3'd4
  } lex_mode_t;

  typedef enum logic [3:0] {
    TOK_END      = 4'd0,
    TOK_EQUALS   = 4'd1,
    TOK_CLOSE    = 4'd2,
    TOK_OPEN     = 4'd3,
    TOK_COMMENT  = 4'd4,
    TOK_CLOSETAG = 4'd5,
    TOK_DECL     = 4'd6,
    TOK_NAME     = 4'd7,
    TOK_STRING   = 4'd8,
    TOK_UNREC    = 4'd9
  } tok_kind_t;

  localparam logic [7:0] CH_AMP   = "&";
  localparam logic [7:0] CH_SEMI  = ";";
  localparam logic [7:0] CH_LT    = "<";
  localparam logic [7:0] CH_GT    = ">";
  localparam logic [7:0] CH_QUOTE = "\"";
  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_BANG  = "!";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_QUEST = "?";
  localparam logic [7:0] CH_UNDER = "_";
  localparam logic [7:0] CH_COLON = ":";
  localparam logic [7:0] CH_SPACE = " ";

  localparam logic [15:0] ENT_LT   = "lt";
  localparam logic [15:0] ENT_GT   = "gt";
  localparam logic [23:0] ENT_AMP  = "amp";
  localparam logic [31:0] ENT_QUOT = "quot";

  typedef struct packed {
    tok_kind_t   kind;
    logic [7:0]  char_value;
    logic        has_char;
    logic        token_done;
  } tok_res_t;

  typedef struct packed {
    logic [1:0]          cnt;
    tok_res_t [2:0]      res;
  } tok_grp_t;

  typedef struct packed {
    lex_mode_t           mode;
    logic [1:0]          n;
    logic                clear;
    tok_res_t [2:0]      res;
  } lex_pass_t;

  function automatic logic is_name_char(logic [7:0] c);
    return (c inside {["A":"Z"], ["a":"z"], ["0":"9"], CH_UNDER, CH_COLON});
  endfunction

  function automatic tok_res_t mk_res(tok_kind_t k, logic [7:0] c, logic h, logic d);
    tok_res_t r;
    r.kind       = k;
    r.char_value = c;
    r.has_char   = h;
    r.token_done = d;
    return r;
  endfunction

  // One decoded character through the token machine. A name or a pending
  // open that is ended by this character hands it on to the idle rules.
  function automatic lex_pass_t lex_pass(lex_mode_t mode, logic [7:0] ch,
                                         logic esc, logic eof);
    lex_pass_t o;
    logic      retry;
    tok_kind_t k;
    o       = '0;
    o.mode  = MODE_IDLE;
    retry   = 1'b0;
    k       = TOK_UNREC;
    case (mode)
      MODE_NAME: begin
        if (!eof && !esc && is_name_char(ch)) begin
          o.res[0] = mk_res(TOK_NAME, ch, 1'b1, 1'b0);
          o.mode   = MODE_NAME;
        end else begin
          o.res[0] = mk_res(TOK_NAME, 8'd0, 1'b0, 1'b1);
          retry    = 1'b1;
        end
        o.n = 2'd1;
      end
      MODE_STRING: begin
        if (eof) begin
          o.res[0] = mk_res(TOK_STRING, 8'd0, 1'b0, 1'b1);
          retry    = 1'b1;
        end else if (!esc && ch == CH_QUOTE) begin
          o.res[0] = mk_res(TOK_STRING, 8'd0, 1'b0, 1'b1);
        end else begin
          o.res[0] = mk_res(TOK_STRING, ch, 1'b1, 1'b0);
          o.mode   = MODE_STRING;
        end
        o.n = 2'd1;
      end
      MODE_AFTLT: begin
        if (!eof && !esc && (ch == CH_BANG || ch == CH_SLASH || ch == CH_QUEST)) begin
          if (ch == CH_BANG) begin
            k = TOK_COMMENT;
          end else if (ch == CH_SLASH) begin
            k = TOK_CLOSETAG;
          end else begin
            k = TOK_DECL;
          end
          o.res[0] = mk_res(k, 8'd0, 1'b0, 1'b1);
        end else begin
          o.res[0] = mk_res(TOK_OPEN, 8'd0, 1'b0, 1'b1);
          retry    = 1'b1;
        end
        o.n = 2'd1;
      end
      default: begin
        retry = 1'b1;
      end
    endcase
    if (retry) begin
      o.mode = MODE_IDLE;
      if (eof) begin
        o.res[o.n] = mk_res(TOK_END, 8'd0, 1'b0, 1'b1);
        o.n        = o.n + 2'd1;
        o.clear    = 1'b1;
      end else if (esc) begin
        o.res[o.n] = mk_res(TOK_UNREC, 8'd0, 1'b0, 1'b1);
        o.n        = o.n + 2'd1;
      end else if (ch <= CH_SPACE) begin
        o.mode = MODE_IDLE;
      end else if (ch == CH_EQ) begin
        o.res[o.n] = mk_res(TOK_EQUALS, 8'd0, 1'b0, 1'b1);
        o.n        = o.n + 2'd1;
      end else if (ch == CH_GT) begin
        o.res[o.n] = mk_res(TOK_CLOSE, 8'd0, 1'b0, 1'b1);
        o.n        = o.n + 2'd1;
      end else if (ch == CH_LT) begin
        o.mode = MODE_AFTLT;
      end else if (is_name_char(ch)) begin
        o.res[o.n] = mk_res(TOK_NAME, ch, 1'b1, 1'b0);
        o.n        = o.n + 2'd1;
        o.mode     = MODE_NAME;
      end else if (ch == CH_QUOTE) begin
        o.mode = MODE_STRING;
      end else begin
        o.res[o.n] = mk_res(TOK_UNREC, 8'd0, 1'b0, 1'b1);
        o.n        = o.n + 2'd1;
      end
    end
    return o;
  endfunction

endpackage

FILE: hw/rtl/xmt_if.sv
`timescale 1ns / 1ps
interface xmt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_input;
  modport source (output valid, output byte_in, output end_of_input, input ready);
  modport sink (input valid, input byte_in, input end_of_input, output ready);
endinterface

interface xmt_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;
  logic [7:0] char_value;
  logic       has_char;
  logic       token_done;
  logic       last_in_run;
  modport source (output valid, output token_kind, output char_value, output has_char,
                  output token_done, output last_in_run, input ready);
  modport sink (input valid, input token_kind, input char_value, input has_char,
                input token_done, input last_in_run, output ready);
endinterface

FILE: hw/rtl/xmt_lexer.sv
`timescale 1ns / 1ps
module xmt_lexer #(
  parameter int ENTITY_MAX = xmt_pkg::ENTITY_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_fire,
  input  logic [7:0]        byte_in,
  input  logic              end_of_input,
  output xmt_pkg::tok_grp_t grp
);
  import xmt_pkg::*;

  localparam int IDXW = $clog2(ENTITY_MAX);
  localparam int LENW = $clog2(ENTITY_MAX + 1);

  lex_mode_t       mode_r, mode_nxt;
  lex_mode_t       resume_r, resume_nxt;
  logic [LENW-1:0] len_r, len_nxt;
  logic            ovf_r, ovf_nxt;
  logic [7:0]      text_r [ENTITY_MAX];
  logic            text_we;

  logic       eof;
  logic       ent_lt, ent_gt, ent_quot, ent_amp;
  logic [7:0] ent_ch;
  logic       ent_esc;
  lex_pass_t  p1, p2;
  logic [1:0] j;

  assign eof = end_of_input || (byte_in == 8'd0);

  assign ent_lt   = !ovf_r && len_r == LENW'(2) && {text_r[0], text_r[1]} == ENT_LT;
  assign ent_gt   = !ovf_r && len_r == LENW'(2) && {text_r[0], text_r[1]} == ENT_GT;
  assign ent_amp  = !ovf_r && len_r == LENW'(3)
                    && {text_r[0], text_r[1], text_r[2]} == ENT_AMP;
  assign ent_quot = !ovf_r && len_r == LENW'(4)
                    && {text_r[0], text_r[1], text_r[2], text_r[3]} == ENT_QUOT;

  always_comb begin
    ent_esc = 1'b1;
    ent_ch  = CH_AMP;
    if (ent_lt) begin
      ent_ch = CH_LT;
    end else if (ent_gt) begin
      ent_ch = CH_GT;
    end else if (ent_quot) begin
      ent_ch = CH_QUOTE;
    end else if (!ent_amp) begin
      ent_esc = 1'b0;
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    resume_nxt = resume_r;
    len_nxt    = len_r;
    ovf_nxt    = ovf_r;
    text_we    = 1'b0;
    p1         = '0;
    p2         = '0;
    if (req_fire) begin
      if (mode_r == MODE_ENTITY) begin
        if (eof) begin
          p1       = lex_pass(resume_r, CH_AMP, 1'b0, 1'b0);
          p2       = lex_pass(p1.mode, 8'd0, 1'b0, 1'b1);
          mode_nxt = p2.mode;
        end else if (byte_in == CH_SEMI) begin
          p1       = lex_pass(resume_r, ent_ch, ent_esc, 1'b0);
          mode_nxt = p1.mode;
          len_nxt  = '0;
          ovf_nxt  = 1'b0;
        end else if (len_r < LENW'(ENTITY_MAX)) begin
          text_we = 1'b1;
          len_nxt = len_r + LENW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end else if (eof) begin
        p1       = lex_pass(mode_r, 8'd0, 1'b0, 1'b1);
        mode_nxt = p1.mode;
      end else if (byte_in == CH_AMP) begin
        resume_nxt = (mode_r <= MODE_AFTLT) ? mode_r : MODE_IDLE;
        mode_nxt   = MODE_ENTITY;
        len_nxt    = '0;
        ovf_nxt    = 1'b0;
      end else begin
        p1       = lex_pass(mode_r, byte_in, 1'b0, 1'b0);
        mode_nxt = p1.mode;
      end
      if (p1.clear || p2.clear) begin
        mode_nxt   = MODE_IDLE;
        resume_nxt = MODE_IDLE;
        len_nxt    = '0;
        ovf_nxt    = 1'b0;
      end
    end
  end

  always_comb begin
    grp     = '0;
    grp.cnt = p1.n + p2.n;
    j       = '0;
    for (int i = 0; i < RES_MAX; i++) begin
      j = 2'(i) - p1.n;
      if (2'(i) < p1.n) begin
        grp.res[i] = p1.res[i];
      end else if (j < p2.n) begin
        grp.res[i] = p2.res[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      resume_r <= MODE_IDLE;
      len_r    <= '0;
      ovf_r    <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      resume_r <= resume_nxt;
      len_r    <= len_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (text_we) begin
      text_r[len_r[IDXW-1:0]] <= byte_in;
    end
  end

endmodule

FILE: hw/rtl/xml_markup_tokenizer_unit.sv
`timescale 1ns / 1ps
// XML markup tokenizer. The in_ch channel carries one raw byte per request,
// with an end flag; a zero byte also ends the stream. Entities are decoded
// in line and the decoded characters drive the token machine.
// The out_ch channel carries token items: a kind, a character for name and
// string characters, a flag on the item that completes a token, and a flag
// on the last item that one input byte caused. A byte causes zero to three
// items, in order.
// Items of an accepted byte are registered in the result queue before they
// are offered. Input bytes are taken one per cycle while each gives at most
// one item and the receiver does not stall; a byte that gives several items
// holds the output port until all of them are taken, and the two-entry
// result queue sets how far the input runs ahead of the output.
// When the receiver stalls, the queue holds its items and in_ch.ready drops
// once both entries are in use; nothing is lost or repeated.
// Synchronous reset returns the lexer to idle with no pending entity and
// empties the result queue. After an end item the lexer is back in its
// reset state and the next byte starts a new stream.
module xml_markup_tokenizer_unit #(
  parameter int ENTITY_MAX = xmt_pkg::ENTITY_MAX_DEF
) (
  input logic      clk,
  input logic      rst_n,
  xmt_in_if.sink   in_ch,
  xmt_out_if.source out_ch
);
  import xmt_pkg::*;

  logic       in_fire, out_fire, push, pop;
  tok_grp_t   grp;
  tok_grp_t   q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r;
  tok_grp_t   cur;
  tok_res_t   res;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign in_fire     = in_ch.valid && in_ch.ready;

  xmt_lexer #(
    .ENTITY_MAX(ENTITY_MAX)
  ) u_lexer (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_fire     (in_fire),
    .byte_in      (in_ch.byte_in),
    .end_of_input (in_ch.end_of_input),
    .grp          (grp)
  );

  assign cur = q_r[rd_ptr_r];
  assign res = cur.res[idx_r];

  assign out_ch.valid       = (cnt_r != 2'd0);
  assign out_ch.token_kind  = res.kind;
  assign out_ch.char_value  = res.char_value;
  assign out_ch.has_char    = res.has_char;
  assign out_ch.token_done  = res.token_done;
  assign out_ch.last_in_run = (idx_r == cur.cnt - 2'd1);

  assign out_fire = out_ch.valid && out_ch.ready;
  assign pop      = out_fire && out_ch.last_in_run;
  assign push     = in_fire && (grp.cnt != 2'd0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      idx_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
        idx_r    <= 2'd0;
      end else if (out_fire) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= grp;
    end
  end

endmodule
